FILE: src/evr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// evr_pkg
// Shared constants and the CORDIC arctangent table for the rotation core.
// ----------------------------------------------------------------------------
package evr_pkg;

  localparam int CordicFrac  = 30;
  localparam logic signed [33:0] CordicStart = 34'sd652032874;

  function automatic logic signed [33:0] atan_turn(input int idx);
    logic signed [33:0] v;
    v = '0;
    unique case (idx)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      24: v = 34'sd41;
      25: v = 34'sd20;
      26: v = 34'sd10;
      27: v = 34'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: src/euler_vector_rotation_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euler_vector_rotation_core
// Rotates a Q16.16 vector about z (yaw), x (pitch), then y (roll).
// ----------------------------------------------------------------------------
// Input beats on in_* carry the vector, three angles and a reverse flag; each
// beat yields exactly one result beat on out_* with the rotated vector.
// The whole datapath is one pipeline that advances when its output slot is
// free or empty, so one beat is taken every cycle while out_tready is high.
// The CORDIC runs STEPS = TRIG_FRAC_BITS+4 steps between its input and output
// registers; then come the three rotation stages, each with a product and a
// result register, and last the output register.
// All three sines and cosines are made in parallel CORDIC pipelines; the
// vector rides a delay line alongside them and meets each stage's trig
// values at the matching depth.
// Reset clears the valid bits only. When the receiver stalls the pipeline
// freezes and in_tready drops once the output holds a beat; nothing is lost.
// ----------------------------------------------------------------------------
module euler_vector_rotation_core #(
  parameter int COORD_WIDTH    = 32,
  parameter int ANGLE_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_tvalid,
  output logic in_tready,
  // vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle (low bit up)
  input  wire  [((3*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] in_tdata,
  input  wire  in_tuser, // reverse
  output logic out_tvalid,
  input  wire  out_tready,
  // rot_x, rot_y, rot_z (low bit up)
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata
);
  import evr_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int Steps = TRIG_FRAC_BITS + 4;
  localparam int TLat = Steps + 2;
  localparam int Lat = TLat + 6;
  localparam int OW = ((3*CW+7)/8)*8;

  logic en;
  logic [Lat-1:0] v_r;
  logic out_tvalid_r;

  assign en = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign out_tvalid = out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[Lat-2:0], in_tvalid};
      out_tvalid_r <= v_r[Lat-1];
    end
  end

  logic [31:0] turn [3];
  for (genvar k = 0; k < 3; k++) begin : g_turn
    logic [31:0] a;
    assign a = {in_tdata[3*CW+k*AW +: AW], (32-AW)'(0)};
    assign turn[k] = in_tuser ? (32'd0 - a) : a;
  end

  logic signed [TW-1:0] sn [3];
  logic signed [TW-1:0] cs [3];
  for (genvar k = 0; k < 3; k++) begin : g_trig
    evr_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .STEPS(Steps)) u_cordic (
      .clk(clk), .en(en), .turn(turn[k]), .sin_o(sn[k]), .cos_o(cs[k]));
  end

  // vector delay line to meet trig output
  logic [3*CW-1:0] vd_r [TLat];
  always_ff @(posedge clk) begin
    if (en) begin
      vd_r[0] <= in_tdata[3*CW-1:0];
      for (int i = 1; i < TLat; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  // trig delay for pitch (sp_r, cp_r) and roll (sr_r, cr_r)
  logic signed [TW-1:0] sp_r [2], cp_r [2], sr_r [4], cr_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      sp_r[0] <= sn[1]; cp_r[0] <= cs[1]; sp_r[1] <= sp_r[0]; cp_r[1] <= cp_r[0];
      sr_r[0] <= sn[0]; cr_r[0] <= cs[0];
      for (int i = 1; i < 4; i++) begin
        sr_r[i] <= sr_r[i-1]; cr_r[i] <= cr_r[i-1];
      end
    end
  end

  logic signed [CW-1:0] x0, y0, z0, x1, y1, z1_r [2], y2, z2, x2_r [2], x3, z3, y3_r [2];
  assign x0 = vd_r[TLat-1][0 +: CW];
  assign y0 = vd_r[TLat-1][CW +: CW];
  assign z0 = vd_r[TLat-1][2*CW +: CW];

  evr_mac #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_zx (
    .clk(clk), .en(en), .a(x0), .c(cs[2]), .b(y0), .d(sn[2]), .res(x1));
  evr_mac #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_zy (
    .clk(clk), .en(en), .a(x0), .c(-sn[2]), .b(y0), .d(cs[2]), .res(y1));
  always_ff @(posedge clk) begin
    if (en) begin
      z1_r[0] <= z0; z1_r[1] <= z1_r[0];
    end
  end

  evr_mac #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_xy (
    .clk(clk), .en(en), .a(y1), .c(cp_r[1]), .b(z1_r[1]), .d(sp_r[1]), .res(y2));
  evr_mac #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_xz (
    .clk(clk), .en(en), .a(y1), .c(-sp_r[1]), .b(z1_r[1]), .d(cp_r[1]), .res(z2));
  always_ff @(posedge clk) begin
    if (en) begin
      x2_r[0] <= x1; x2_r[1] <= x2_r[0];
    end
  end

  evr_mac #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_yx (
    .clk(clk), .en(en), .a(x2_r[1]), .c(cr_r[3]), .b(z2), .d(-sr_r[3]), .res(x3));
  evr_mac #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_yz (
    .clk(clk), .en(en), .a(x2_r[1]), .c(sr_r[3]), .b(z2), .d(cr_r[3]), .res(z3));
  always_ff @(posedge clk) begin
    if (en) begin
      y3_r[0] <= y2; y3_r[1] <= y3_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= OW'({z3, y3_r[1], x3});
    end
  end

endmodule
`default_nettype wire

FILE: src/evr_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// evr_cordic
// Pipelined sine/cosine: half-turn fold, one CORDIC step per stage, rounding.
// ----------------------------------------------------------------------------
module evr_cordic #(
  parameter int TRIG_FRAC_BITS = 15,
  parameter int STEPS          = 19
) (
  input  wire                              clk,
  input  wire                              en,
  input  wire  [31:0]                      turn,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);
  import evr_pkg::*;

  localparam int Sh = CordicFrac - TRIG_FRAC_BITS;
  localparam int TW = TRIG_FRAC_BITS + 2;

  logic signed [33:0] x_r [STEPS+1];
  logic signed [33:0] y_r [STEPS+1];
  logic signed [33:0] z_r [STEPS+1];
  logic               f_r [STEPS+1];

  logic signed [33:0] z0;
  logic               f0;

  always_comb begin
    z0 = 34'(signed'(turn));
    f0 = 1'b0;
    if (z0 > 34'sd1073741824) begin
      z0 = z0 - 34'sd2147483648;
      f0 = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      z0 = z0 + 34'sd2147483648;
      f0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CordicStart;
      y_r[0] <= '0;
      z_r[0] <= z0;
      f_r[0] <= f0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [33:0] At = atan_turn(i);
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - At;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + At;
        end
      end
    end
  end

  logic signed [33:0] xr, yr;
  always_comb begin
    xr = (x_r[STEPS] + (34'sd1 <<< (Sh - 1))) >>> Sh;
    yr = (y_r[STEPS] + (34'sd1 <<< (Sh - 1))) >>> Sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= f_r[STEPS] ? -xr[TW-1:0] : xr[TW-1:0];
      sin_o <= f_r[STEPS] ? -yr[TW-1:0] : yr[TW-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/evr_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// evr_mac
// Two-stage a*c + b*d with rounding and saturation to the coordinate range.
// ----------------------------------------------------------------------------
module evr_mac #(
  parameter int COORD_WIDTH    = 32,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  wire                              clk,
  input  wire                              en,
  input  wire  signed [COORD_WIDTH-1:0]    a,
  input  wire  signed [TRIG_FRAC_BITS+1:0] c,
  input  wire  signed [COORD_WIDTH-1:0]    b,
  input  wire  signed [TRIG_FRAC_BITS+1:0] d,
  output logic signed [COORD_WIDTH-1:0]    res
);
  localparam int PW = COORD_WIDTH + TRIG_FRAC_BITS + 2;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] Hi = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [SW-1:0] Lo = -Hi - SW'(1);

  logic signed [PW-1:0] p0_r, p1_r;
  logic signed [SW-1:0] s;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= PW'(a) * PW'(c);
      p1_r <= PW'(b) * PW'(d);
    end
  end

  always_comb begin
    s = (SW'(p0_r) + SW'(p1_r) + (SW'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s > Hi) begin
        res <= Hi[COORD_WIDTH-1:0];
      end else if (s < Lo) begin
        res <= Lo[COORD_WIDTH-1:0];
      end else begin
        res <= s[COORD_WIDTH-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: bench/evr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_checker
// Watches both stream channels of the rotation core, predicts each rotated
// vector from the accepted input beat and compares it with the output beat.
// ----------------------------------------------------------------------------
module evr_checker (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  input  wire          in_tready,
  input  wire  [143:0] in_tdata,
  input  wire          in_tuser,
  input  wire          out_tvalid,
  input  wire          out_tready,
  input  wire  [95:0]  out_tdata,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vec_t;

  localparam int TrigFrac = 15;
  localparam int Steps    = TrigFrac + 4;
  localparam longint CordicGainInv = 652032874;
  localparam longint AtanTurn [0:Steps-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608
  };

  vec_t expected_rot[$];

  // sine and cosine of a 32-bit turn angle with TrigFrac fraction bits
  function automatic void sin_cos(input logic [31:0] turn, output longint sn,
                                  output longint cs);
    longint ang, cx, cy, t;
    bit flip;
    ang = longint'($signed(turn));
    cx = CordicGainInv;
    cy = 0;
    flip = 0;
    if (ang > (64'sd1 <<< 30)) begin
      ang -= 64'sd1 <<< 31;
      flip = 1;
    end else if (ang < -(64'sd1 <<< 30)) begin
      ang += 64'sd1 <<< 31;
      flip = 1;
    end
    for (int i = 0; i < Steps; i++) begin
      if (ang >= 0) begin
        t = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        ang -= AtanTurn[i];
      end else begin
        t = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        ang += AtanTurn[i];
      end
      cx = t;
    end
    cx = (cx + (64'sd1 <<< 14)) >>> 15;
    cy = (cy + (64'sd1 <<< 14)) >>> 15;
    cs = flip ? -cx : cx;
    sn = flip ? -cy : cy;
  endfunction

  // round (a*c + b*d) / 2^TrigFrac half up, then clamp to 32 bits
  function automatic longint dot2(input longint a, input longint c, input longint b,
                                  input longint d);
    longint s;
    s = (a * c + b * d + (64'sd1 <<< (TrigFrac - 1))) >>> TrigFrac;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic logic [31:0] angle_turn(input logic [15:0] ang, input bit rev);
    logic [31:0] a;
    a = {ang, 16'h0000};
    return rev ? -a : a;
  endfunction

  function automatic vec_t rotate_zxy(input logic [143:0] d, input bit rev);
    longint x, y, z, x1, y1, sr, cr, sp, cp, sy, cy;
    vec_t r;
    x = longint'($signed(d[31:0]));
    y = longint'($signed(d[63:32]));
    z = longint'($signed(d[95:64]));
    sin_cos(angle_turn(d[111:96], rev), sr, cr);
    sin_cos(angle_turn(d[127:112], rev), sp, cp);
    sin_cos(angle_turn(d[143:128], rev), sy, cy);
    // yaw about z
    x1 = dot2(x, cy, y, sy);
    y1 = dot2(x, -sy, y, cy);
    // pitch about x
    y = dot2(y1, cp, z, sp);
    z = dot2(y1, -sp, z, cp);
    // roll about y
    r.x = 32'(dot2(x1, cr, z, -sr));
    r.y = 32'(y);
    r.z = 32'(dot2(x1, sr, z, cr));
    return r;
  endfunction

  assign pending = expected_rot.size();

  always @(posedge clk) begin
    vec_t want, got;
    if (!rst_n) begin
      expected_rot.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_rot.push_back(rotate_zxy(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_rot.size() == 0) begin
          if (fail_count < 10) $display("unexpected output beat %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_rot.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
            if (fail_count < 10)
              $display("mismatch: want x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                       want.x, want.y, want.z, got.x, got.y, got.z);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random vectors and angles into the rotation core with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RandomItems = 1200;
  localparam int StallLimit  = 5000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  int           fail_count;
  int           pending;
  int           idle_cycles;
  int           stall_left;
  bit           burst_mode;

  euler_vector_rotation_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  evr_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (burst_mode || r < 70) return 0;
    if (r < 96) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return 32'($signed($urandom_range(2097152)) - 1048576);
      1:       return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                        : 32'h8000_0000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // present one beat; keep valid high into the next beat when no gap follows
  task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                          input logic [15:0] roll, input logic [15:0] pitch,
                          input logic [15:0] yaw, input bit rev);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yaw, pitch, roll, z, y, x};
    in_tuser  <= rev;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // output stalls: mostly short, now and then a long one, with stretches of none
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (burst_mode) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < 3) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(40, 10);
    end else begin
      out_tready <= ($urandom_range(99) < 75);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [15:0] ang;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    burst_mode = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero and extreme angles, reverse of the most negative angle,
    // full-scale vectors that saturate
    send_vec(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0, 16'h0, 16'h0, 0);
    send_vec(32'h0001_0000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000, 0);
    send_vec(32'h0001_0000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000, 1);
    send_vec(32'h0, 32'h0001_0000, 32'h0, 16'h0, 16'hc000, 16'h0, 0);
    send_vec(32'h0, 32'h0, 32'h0001_0000, 16'h8000, 16'h0, 16'h0, 0);
    send_vec(32'h0, 32'h0, 32'h0001_0000, 16'h8000, 16'h8000, 16'h8000, 1);
    send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h2000, 16'h2000, 16'h2000, 0);
    send_vec(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'he000, 16'h2000, 16'he000, 1);
    send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h4001, 16'hbfff, 16'h0001, 0);
    send_vec(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 16'hffff, 16'h0001, 16'hffff, 1);
    send_vec(32'h0, 32'h0, 32'h0, 16'h1234, 16'h5678, 16'h9abc, 0);
    for (int i = 0; i < 8; i++) begin
      ang = 16'(i * 16'h2000);
      send_vec(32'h0001_8000, 32'hfffe_4000, 32'h0000_c000, ang, ang + 16'h1000,
               ang + 16'h3000, i[0]);
    end

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) burst_mode = ($urandom_range(3) == 0);
      send_vec(rand_coord(), rand_coord(), rand_coord(), 16'($urandom), 16'($urandom),
               16'($urandom), $urandom_range(1));
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
src/evr_pkg.sv
src/evr_cordic.sv
src/evr_mac.sv
src/euler_vector_rotation_core.sv
bench/evr_checker.sv
bench/tb_top.sv
